// ===== sv/swt_pkg.sv =====
// Shared types, constants and register codes for the saturation waveshaper.
package swt_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int DIV_W       = 50;
  localparam int DEN_W       = 28;
  localparam int CNT_W       = 6;
  localparam int DIV_STEPS   = DIV_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [31:0]            word_t;
  typedef logic signed [63:0]            prod_t;

  localparam logic [2:0] REG_AMOUNT    = 3'd0;
  localparam logic [2:0] REG_TONE      = 3'd1;
  localparam logic [2:0] REG_CHARACTER = 3'd2;
  localparam logic [2:0] REG_SMOOTHING = 3'd3;
  localparam logic [2:0] REG_LOWPASS   = 3'd4;
  localparam logic [2:0] REG_FADE_STEP = 3'd5;
  localparam logic [2:0] REG_CHANNELS  = 3'd6;

  localparam logic [1:0] CH_CLEAN  = 2'd0;
  localparam logic [1:0] CH_WARM   = 2'd1;
  localparam logic [1:0] CH_EDGE   = 2'd2;
  localparam logic [1:0] CH_BYPASS = 2'd3;

  localparam logic [16:0] FADE_FULL  = 17'd65536;
  localparam logic [16:0] AMOUNT_MAX = 17'd65536;

  localparam word_t ONE_Q20     = 32'sd1048576;
  localparam word_t THREE_Q20   = 32'sd3145728;
  localparam word_t CLIP_Q20    = 32'sd33554432;
  localparam word_t TANH_K27    = 32'sd28311552;
  localparam word_t GAIN_ONE    = 32'sd65536;
  localparam word_t K_BIAS      = 32'sd11796;
  localparam word_t K_WARM_POS  = 32'sd53740;
  localparam word_t K_WARM_NEG  = 32'sd70779;
  localparam word_t K_EDGE      = 32'sd14418;
  localparam word_t K_EDGE_GAIN = 32'sd111411;
  localparam word_t EDGE_LO     = -32'sd1310720;
  localparam word_t EDGE_HI     = 32'sd964690;
  localparam word_t ATAN_C      = 32'sd294912;
  localparam word_t HALF_PI     = 32'sd1647099;
  localparam word_t TWO_OVER_PI = 32'sd667544;
  localparam word_t MIX_TANH    = 32'sd47186;
  localparam word_t MIX_ATAN    = 32'sd18350;
  localparam word_t TILT_UP     = 32'sd29491;
  localparam word_t TILT_DOWN   = 32'sd49152;
  localparam word_t SAMPLE_MAX  = 32'sd8388607;
  localparam word_t SAMPLE_MIN  = -32'sd8388608;

  typedef struct packed {
    logic [16:0]        amount_target;
    logic signed [16:0] tone_target;
    logic [15:0]        smoothing_coeff;
    logic [15:0]        lowpass_coeff;
    logic [16:0]        fade_step;
    logic               two_lanes;
    logic               char_wr;
    logic [1:0]         char_val;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_SMA, ST_SMT, ST_FADE, ST_GAIN, ST_BIAS, ST_KEDGE, ST_TONEG,
    ST_TBIAS, ST_LANE, ST_SH0, ST_SH1, ST_SH2, ST_SHCL, ST_WA1, ST_WA2,
    ST_ED1, ST_ED2, ST_EDW, ST_ED3, ST_ED4, ST_ED5,
    ST_AT0, ST_AT1, ST_AT2, ST_ATW, ST_AT3, ST_AT4, ST_AT5, ST_AT6, ST_AT7,
    ST_SHDONE, ST_MX0, ST_MX1, ST_MX2, ST_MX3, ST_MX4, ST_MX5,
    ST_LNEXT, ST_EMIT, ST_TH0, ST_TH1, ST_TH2, ST_THW
  } state_t;

endpackage

// ===== sv/swt_mul.sv =====
// Shared signed 32x32 multiplier with registered product.
module swt_mul (
  input  logic          clk,
  input  swt_pkg::word_t mul_a,
  input  swt_pkg::word_t mul_b,
  output swt_pkg::prod_t prod
);
  import swt_pkg::*;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

endmodule

// ===== sv/swt_div.sv =====
// Shared bit-serial restoring divider, one quotient bit per cycle.
module swt_div (
  input  logic               clk,
  input  logic               rst,
  input  swt_pkg::div_req_t  req,
  output swt_pkg::div_rsp_t  rsp
);
  import swt_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= CNT_W'(DIV_STEPS);
      den <= req.divisor;
      rem <= '0;
      quo <= req.dividend;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      rem <= fits ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== sv/swt_cfg.sv =====
// Configuration register file behind the APB-style port.
module swt_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swt_pkg::ADDR_W-1:0] paddr,
  input  logic [swt_pkg::DATA_W-1:0] pwdata,
  output logic [swt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output swt_pkg::cfg_t              cfg
);
  import swt_pkg::*;

  logic [16:0]        amount_target;
  logic signed [16:0] tone_target;
  logic [1:0]         character_select;
  logic [15:0]        smoothing_coeff;
  logic [15:0]        lowpass_coeff;
  logic [16:0]        fade_step;
  logic [1:0]         active_channels;
  logic               wr;
  logic [2:0]         idx;
  logic signed [16:0] tone_in;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign idx     = paddr[4:2];
  assign tone_in = $signed(pwdata[16:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      amount_target    <= '0;
      tone_target      <= '0;
      character_select <= CH_CLEAN;
      smoothing_coeff  <= 16'd65000;
      lowpass_coeff    <= 16'd45000;
      fade_step        <= 17'd34;
      active_channels  <= 2'd2;
    end else if (wr) begin
      case (idx)
        REG_AMOUNT:    amount_target <= (pwdata[16:0] > AMOUNT_MAX) ? AMOUNT_MAX
                                                                     : pwdata[16:0];
        REG_TONE:      tone_target <= (tone_in < -17'sd32768) ? -17'sd32768
                                      : ((tone_in > 17'sd32768) ? 17'sd32768 : tone_in);
        REG_CHARACTER: character_select <= pwdata[1:0];
        REG_SMOOTHING: smoothing_coeff <= pwdata[15:0];
        REG_LOWPASS:   lowpass_coeff <= pwdata[15:0];
        REG_FADE_STEP: fade_step <= pwdata[16:0];
        REG_CHANNELS:  active_channels <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_AMOUNT:    prdata = {15'b0, amount_target};
      REG_TONE:      prdata = {{15{tone_target[16]}}, tone_target};
      REG_CHARACTER: prdata = {30'b0, character_select};
      REG_SMOOTHING: prdata = {16'b0, smoothing_coeff};
      REG_LOWPASS:   prdata = {16'b0, lowpass_coeff};
      REG_FADE_STEP: prdata = {15'b0, fade_step};
      REG_CHANNELS:  prdata = {30'b0, active_channels};
      default:       prdata = '0;
    endcase
  end

  assign cfg.amount_target   = amount_target;
  assign cfg.tone_target     = tone_target;
  assign cfg.smoothing_coeff = smoothing_coeff;
  assign cfg.lowpass_coeff   = lowpass_coeff;
  assign cfg.fade_step       = fade_step;
  assign cfg.two_lanes       = active_channels[1];
  assign cfg.char_wr         = wr && (idx == REG_CHARACTER);
  assign cfg.char_val        = pwdata[1:0];

endmodule

// ===== sv/swt_core.sv =====
// Sequencer and datapath registers driving the shared multiplier and divider.
module swt_core (
  input  logic             clk,
  input  logic             rst,
  input  swt_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  swt_pkg::sample_t sample_left,
  input  swt_pkg::sample_t sample_right,
  output logic             out_valid,
  input  logic             out_stall,
  output swt_pkg::sample_t driven_left,
  output swt_pkg::sample_t driven_right
);
  import swt_pkg::*;

  state_t             state, state_next, ret_state;
  sample_t            x0, x1, xcur, lp0, lp1, lp_cur, y0, y1, lo_r;
  logic [16:0]        amount_now;
  logic signed [16:0] tone_now;
  logic [16:0]        fade_level;
  logic [17:0]        fade_sum;
  logic [1:0]         old_char, new_char, ch_cur;
  logic               lane, pass_new, th_neg, at_neg, at_small, tone_neg, slot_free;
  logic [19:0]        gain;
  logic [17:0]        bias;
  logic [13:0]        kedge;
  logic [14:0]        tgain;
  logic [DEN_W-1:0]   th_den;
  word_t              tbias, in_r, th_x, th_res, sh_res, prev_r, next_r, d_r;
  word_t              c_r, t_r, z_r, z2_r, r_r, u_r, acc_r;
  word_t              mul_a, mul_b, p12, p15, p16, p20, quo_w, in_abs, c_sum;
  word_t              amt_diff, tone_diff, low_w, y_w, gain_w, c_abs, lp_w, x_w;
  prod_t              prod, prod_abs;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  function automatic sample_t sat_sample(word_t v);
    word_t r;
    r = (v > SAMPLE_MAX) ? SAMPLE_MAX : ((v < SAMPLE_MIN) ? SAMPLE_MIN : v);
    return sample_t'(r);
  endfunction

  swt_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  swt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign p12       = word_t'(prod >>> 12);
  assign p15       = word_t'(prod >>> 15);
  assign p16       = word_t'(prod >>> 16);
  assign p20       = word_t'(prod >>> 20);
  assign prod_abs  = (prod < 0) ? -prod : prod;
  assign quo_w     = word_t'(div_rsp.quotient[31:0]);
  assign xcur      = lane ? x1 : x0;
  assign x_w       = word_t'(xcur);
  assign lp_cur    = lane ? lp1 : lp0;
  assign lp_w      = word_t'(lp_cur);
  assign in_abs    = (in_r < 0) ? -in_r : in_r;
  assign c_abs     = (c_r < 0) ? -c_r : c_r;
  assign c_sum     = in_r + quo_w;
  assign amt_diff  = $signed({15'b0, amount_now}) - $signed({15'b0, cfg.amount_target});
  assign tone_diff = word_t'(tone_now) - word_t'(cfg.tone_target);
  assign fade_sum  = {1'b0, fade_level} + {1'b0, cfg.fade_step};
  assign low_w     = d_r + p16;
  assign y_w       = d_r + p15;
  assign gain_w    = GAIN_ONE + (p16 <<< 4) - (p16 <<< 1);
  assign in_stall  = (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SMA;
      ST_SMA:    state_next = ST_SMT;
      ST_SMT:    state_next = ST_FADE;
      ST_FADE:   state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_BIAS;
      ST_BIAS:   state_next = ST_KEDGE;
      ST_KEDGE:  state_next = ST_TONEG;
      ST_TONEG:  state_next = ST_TH0;
      ST_TBIAS:  state_next = ST_LANE;
      ST_LANE:   state_next = (!lane || cfg.two_lanes) ? ST_SH0 : ST_LNEXT;
      ST_SH0:    state_next = (amount_now == '0 || ch_cur == CH_BYPASS) ? ST_SHDONE
                                                                          : ST_SH1;
      ST_SH1:    state_next = ST_SH2;
      ST_SH2: begin
        case (ch_cur)
          CH_CLEAN: state_next = ST_TH0;
          CH_WARM:  state_next = ST_WA1;
          default:  state_next = ST_ED1;
        endcase
      end
      ST_SHCL:   state_next = ST_SHDONE;
      ST_WA1:    state_next = ST_TH0;
      ST_WA2:    state_next = ST_SHDONE;
      ST_ED1:    state_next = ST_ED2;
      ST_ED2:    state_next = ST_EDW;
      ST_EDW:    if (div_rsp.done) state_next = ST_ED3;
      ST_ED3:    state_next = ST_ED4;
      ST_ED4:    state_next = ST_TH0;
      ST_ED5:    state_next = ST_AT0;
      ST_AT0:    state_next = ST_AT1;
      ST_AT1:    state_next = ST_AT2;
      ST_AT2:    state_next = ST_ATW;
      ST_ATW:    if (div_rsp.done) state_next = ST_AT3;
      ST_AT3:    state_next = ST_AT4;
      ST_AT4:    state_next = ST_AT5;
      ST_AT5:    state_next = ST_AT6;
      ST_AT6:    state_next = ST_AT7;
      ST_AT7:    state_next = ST_SHDONE;
      ST_SHDONE: state_next = pass_new ? ST_MX0 : ST_SH0;
      ST_MX0:    state_next = ST_MX1;
      ST_MX1:    state_next = ST_MX2;
      ST_MX2:    state_next = ST_MX3;
      ST_MX3:    state_next = ST_MX4;
      ST_MX4:    state_next = ST_MX5;
      ST_MX5:    state_next = ST_LNEXT;
      ST_LNEXT:  state_next = lane ? ST_EMIT : ST_LANE;
      ST_EMIT:   if (slot_free) state_next = ST_IDLE;
      ST_TH0:    state_next = (th_x >= THREE_Q20 || th_x <= -THREE_Q20) ? ret_state
                                                                          : ST_TH1;
      ST_TH1:    state_next = ST_TH2;
      ST_TH2:    state_next = ST_THW;
      ST_THW:    if (div_rsp.done) state_next = ret_state;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    case (state)
      ST_SMA: begin
        mul_a = $signed({16'b0, cfg.smoothing_coeff});
        mul_b = amt_diff;
      end
      ST_SMT: begin
        mul_a = $signed({16'b0, cfg.smoothing_coeff});
        mul_b = tone_diff;
      end
      ST_FADE: begin
        mul_a = $signed({15'b0, amount_now});
        mul_b = $signed({15'b0, amount_now});
      end
      ST_GAIN: begin
        mul_a = K_BIAS;
        mul_b = $signed({15'b0, amount_now});
      end
      ST_BIAS: begin
        mul_a = K_EDGE;
        mul_b = $signed({15'b0, amount_now});
      end
      ST_KEDGE: begin
        mul_a = (tone_now < 0) ? -word_t'(tone_now) : word_t'(tone_now);
        mul_b = (tone_now < 0) ? TILT_DOWN : TILT_UP;
      end
      ST_SH0: begin
        mul_a = x_w;
        mul_b = $signed({12'b0, gain});
      end
      ST_SH2: begin
        if (ch_cur == CH_WARM) begin
          mul_a = in_r + $signed({14'b0, bias});
          mul_b = (in_r >= 0) ? K_WARM_POS : K_WARM_NEG;
        end else begin
          mul_a = in_r;
          mul_b = in_r;
        end
      end
      ST_ED1: begin
        mul_a = $signed({18'b0, kedge});
        mul_b = p20;
      end
      ST_ED2: begin
        div_req.start    = 1'b1;
        div_req.dividend = {prod[DIV_W-5:0], 4'b0};
        div_req.divisor  = DEN_W'(ONE_Q20 + in_abs);
      end
      ST_ED3: begin
        mul_a = c_r;
        mul_b = K_EDGE_GAIN;
      end
      ST_AT0: begin
        mul_a = z_r;
        mul_b = z_r;
      end
      ST_AT1: begin
        mul_a = ATAN_C;
        mul_b = p20;
      end
      ST_AT2: begin
        div_req.start    = 1'b1;
        div_req.dividend = {z_r[DIV_W-21:0], 20'b0};
        div_req.divisor  = at_small ? DEN_W'(ONE_Q20 + p20) : DEN_W'(z2_r + ATAN_C);
      end
      ST_AT3: begin
        mul_a = r_r;
        mul_b = TWO_OVER_PI;
      end
      ST_AT5: begin
        mul_a = MIX_TANH;
        mul_b = t_r;
      end
      ST_AT6: begin
        mul_a = MIX_ATAN;
        mul_b = u_r;
      end
      ST_MX0: begin
        mul_a = $signed({15'b0, fade_level});
        mul_b = next_r - prev_r;
      end
      ST_MX2: begin
        mul_a = $signed({16'b0, cfg.lowpass_coeff});
        mul_b = lp_w - d_r;
      end
      ST_MX4: begin
        mul_a = $signed({17'b0, tgain});
        mul_b = tone_neg ? (word_t'(lo_r) - d_r) : (d_r - word_t'(lo_r));
      end
      ST_TH0: begin
        mul_a = th_x;
        mul_b = th_x;
      end
      ST_TH1: begin
        mul_a = th_x;
        mul_b = TANH_K27 + p20;
      end
      ST_TH2: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_abs[DIV_W-1:0];
        div_req.divisor  = th_den;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amount_now <= '0;
      tone_now   <= '0;
      fade_level <= FADE_FULL;
      old_char   <= CH_CLEAN;
      new_char   <= CH_CLEAN;
      lp0        <= '0;
      lp1        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.char_wr && cfg.char_val != new_char) begin
        old_char   <= new_char;
        new_char   <= cfg.char_val;
        fade_level <= '0;
      end
      if (state == ST_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_SMT: begin
          amount_now <= (p16 >= -32'sd1 && p16 <= 32'sd1) ? cfg.amount_target
                        : 17'($signed({15'b0, cfg.amount_target}) + p16);
        end
        ST_FADE: begin
          tone_now   <= (p16 >= -32'sd1 && p16 <= 32'sd1) ? cfg.tone_target
                        : 17'(word_t'(cfg.tone_target) + p16);
          fade_level <= (fade_sum > {1'b0, FADE_FULL}) ? FADE_FULL : fade_sum[16:0];
        end
        ST_MX3: begin
          if (lane) lp1 <= sat_sample(low_w);
          else      lp0 <= sat_sample(low_w);
        end
        ST_EMIT: begin
          if (slot_free && fade_level == FADE_FULL) old_char <= new_char;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      driven_left  <= y0;
      driven_right <= y1;
    end
    case (state)
      ST_IDLE: begin
        x0 <= sample_left;
        x1 <= sample_right;
      end
      ST_GAIN:  gain <= 20'(gain_w);
      ST_BIAS:  bias <= 18'(p12);
      ST_KEDGE: begin
        kedge    <= 14'(p16);
        tone_neg <= tone_now < 0;
      end
      ST_TONEG: begin
        tgain     <= 15'(p16);
        th_x      <= $signed({14'b0, bias});
        ret_state <= ST_TBIAS;
        lane      <= 1'b0;
      end
      ST_TBIAS: tbias <= th_res;
      ST_LANE: begin
        pass_new <= 1'b0;
        ch_cur   <= old_char;
        if (lane && !cfg.two_lanes) y1 <= x1;
      end
      ST_SH0: begin
        if (amount_now == '0 || ch_cur == CH_BYPASS) sh_res <= x_w;
      end
      ST_SH1: in_r <= (p16 > CLIP_Q20) ? CLIP_Q20 : ((p16 < -CLIP_Q20) ? -CLIP_Q20 : p16);
      ST_SH2: begin
        if (ch_cur == CH_CLEAN) begin
          th_x      <= in_r;
          ret_state <= ST_SHCL;
        end
      end
      ST_SHCL: sh_res <= th_res;
      ST_WA1: begin
        th_x      <= p16;
        ret_state <= ST_WA2;
      end
      ST_WA2: sh_res <= th_res - tbias;
      ST_EDW: begin
        c_r <= (c_sum > EDGE_HI) ? EDGE_HI : ((c_sum < EDGE_LO) ? EDGE_LO : c_sum);
      end
      ST_ED4: begin
        th_x      <= p16;
        ret_state <= ST_ED5;
      end
      ST_ED5: begin
        t_r    <= th_res;
        at_neg <= c_r < 0;
        z_r    <= c_abs <<< 2;
      end
      ST_AT1: begin
        z2_r     <= p20;
        at_small <= z_r <= ONE_Q20;
      end
      ST_ATW: r_r <= at_small ? quo_w : HALF_PI - quo_w;
      ST_AT4: u_r <= at_neg ? -p20 : p20;
      ST_AT6: acc_r <= p16;
      ST_AT7: sh_res <= acc_r + p16;
      ST_SHDONE: begin
        if (pass_new) begin
          next_r <= sh_res;
        end else begin
          prev_r   <= sh_res;
          pass_new <= 1'b1;
          ch_cur   <= new_char;
        end
      end
      ST_MX1: d_r <= prev_r + p16;
      ST_MX3: lo_r <= sat_sample(low_w);
      ST_MX5: begin
        if (lane) y1 <= sat_sample(y_w);
        else      y0 <= sat_sample(y_w);
      end
      ST_LNEXT: lane <= 1'b1;
      ST_TH0: begin
        if (th_x >= THREE_Q20)       th_res <= ONE_Q20;
        else if (th_x <= -THREE_Q20) th_res <= -ONE_Q20;
      end
      ST_TH1: th_den <= DEN_W'(TANH_K27 + (p20 <<< 3) + p20);
      ST_TH2: th_neg <= prod < 0;
      ST_THW: th_res <= th_neg ? -quo_w : quo_w;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result raised outside emit");
  a_fade_bound: assert property (@(posedge clk) disable iff (rst)
    fade_level <= FADE_FULL)
    else $error("fade level beyond full");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_THW || state == ST_EDW || state == ST_ATW))
    else $error("divider finished outside a wait state");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == ST_SMA)
    else $error("accepted transaction did not start smoothing");
  a_amount_bound: assert property (@(posedge clk) disable iff (rst)
    amount_now <= AMOUNT_MAX)
    else $error("smoothed amount out of range");
`endif

endmodule

// ===== sv/saturation_waveshaper_tone_tilt_top.sv =====
// Top level of the saturation waveshaper with tone tilt.
// Tanh calls whose input is not clipped, the edge-curve division and the arctangent division
// each wait on the shared bit-serial divider.
// The next frame is taken in the idle state after the emit; a stalled previous result holds
// the sequencer before the new one loads.
// Synchronous reset restores register defaults, idles sequencer and divider, and ends the fade.
module saturation_waveshaper_tone_tilt_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swt_pkg::ADDR_W-1:0] paddr,
  input  logic [swt_pkg::DATA_W-1:0] pwdata,
  output logic [swt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  swt_pkg::sample_t           sample_left,
  input  swt_pkg::sample_t           sample_right,
  output logic                       out_valid,
  input  logic                       out_stall,
  output swt_pkg::sample_t           driven_left,
  output swt_pkg::sample_t           driven_right
);
  import swt_pkg::*;

  cfg_t cfg;

  swt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .driven_left  (driven_left),
    .driven_right (driven_right)
  );

endmodule
